/* design/srsp_pkg.sv */
// Shared types and constants for the snapshot record stream parser.
// Used by every module of the block and by its checker.
package srsp_pkg;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       is_last;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  byte_kind;
        logic [7:0]  data_byte;
        logic        key_end;
        logic        record_end;
        logic [63:0] entry_number;
        logic [63:0] entry_total;
        logic [63:0] saved_time;
        logic [2:0]  status;
    } out_item_t;

    typedef enum logic [3:0] {
        PH_SIG   = 4'd0,
        PH_VER   = 4'd1,
        PH_TIME  = 4'd2,
        PH_COUNT = 4'd3,
        PH_KLEN  = 4'd4,
        PH_KEY   = 4'd5,
        PH_VLEN  = 4'd6,
        PH_VAL   = 4'd7,
        PH_CSUM  = 4'd8,
        PH_STOP  = 4'd9
    } phase_t;

    localparam logic [2:0] KIND_HEADER  = 3'd0;
    localparam logic [2:0] KIND_KEY     = 3'd1;
    localparam logic [2:0] KIND_VALUE   = 3'd2;
    localparam logic [2:0] KIND_LENGTH  = 3'd3;
    localparam logic [2:0] KIND_CSUM    = 3'd4;
    localparam logic [2:0] KIND_IGNORED = 3'd5;

    localparam logic [2:0] STAT_BUSY        = 3'd0;
    localparam logic [2:0] STAT_MATCH       = 3'd1;
    localparam logic [2:0] STAT_MISMATCH    = 3'd2;
    localparam logic [2:0] STAT_BAD_MAGIC   = 3'd3;
    localparam logic [2:0] STAT_BAD_VERSION = 3'd4;
    localparam logic [2:0] STAT_TRUNCATED   = 3'd5;

    localparam logic [2:0]  SIG_LEN         = 3'd6;
    localparam logic [2:0]  SIG_LAST_INDEX  = 3'd6;
    localparam logic [31:0] VERSION_RESET   = 32'd1;

    // Signature characters checked at the head of the file.
    function automatic logic [7:0] sig_byte(input logic [2:0] idx);
        logic [7:0] val;
        unique case (idx)
            3'd0:    val = 8'h4F;
            3'd1:    val = 8'h72;
            3'd2:    val = 8'h63;
            3'd3:    val = 8'h61;
            3'd4:    val = 8'h44;
            3'd5:    val = 8'h42;
            default: val = 8'h00;
        endcase
        return val;
    endfunction

endpackage

/* design/srsp_core.sv */
// Parse state and the per-byte step: framing, gathering, hashing, status.
// Depends on srsp_pkg.
module srsp_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  srsp_pkg::in_item_t  item,
    input  logic [31:0]         expected_version,
    output srsp_pkg::out_item_t result
);

    srsp_pkg::phase_t phase_reg, phase_next;
    logic [2:0]  idx_reg, idx_next;
    logic [63:0] acc_reg, acc_next;
    logic [63:0] records_left_reg, records_left_next;
    logic [31:0] payload_left_reg, payload_left_next;
    logic [31:0] hash_reg, hash_next;
    logic [31:0] sum_reg, sum_next;
    logic [63:0] record_total_reg, record_total_next;
    logic [63:0] header_time_reg, header_time_next;
    logic [63:0] record_index_reg, record_index_next;
    logic [2:0]  status_reg, status_next;

    logic [7:0]  b;
    logic [2:0]  idx_inc;
    logic [63:0] acc_or;
    logic [31:0] hash_step;
    logic [63:0] records_dec;
    logic [2:0]  kind;
    logic        kend;
    logic        rend;
    logic [2:0]  st;

    assign b           = item.byte_value;
    assign idx_inc     = idx_reg + 3'd1;
    assign acc_or      = acc_reg | ({56'd0, b} << {idx_reg, 3'b000});
    assign hash_step   = {hash_reg[26:0], 5'd0} - hash_reg + {24'd0, b};
    assign records_dec = records_left_reg - 64'd1;

    always_comb
    begin
        phase_next        = phase_reg;
        idx_next          = idx_reg;
        acc_next          = acc_reg;
        records_left_next = records_left_reg;
        payload_left_next = payload_left_reg;
        hash_next         = hash_reg;
        sum_next          = sum_reg;
        record_total_next = record_total_reg;
        header_time_next  = header_time_reg;
        record_index_next = record_index_reg;
        status_next       = status_reg;
        kind              = srsp_pkg::KIND_IGNORED;
        kend              = 1'b0;
        rend              = 1'b0;

        unique case (phase_reg)
            srsp_pkg::PH_SIG:
            begin
                kind = srsp_pkg::KIND_HEADER;
                if (idx_reg < srsp_pkg::SIG_LEN && b != srsp_pkg::sig_byte(idx_reg))
                begin
                    status_next = srsp_pkg::STAT_BAD_MAGIC;
                    phase_next  = srsp_pkg::PH_STOP;
                end
                else if (idx_reg == srsp_pkg::SIG_LAST_INDEX)
                begin
                    // seventh byte is taken unchecked
                    idx_next   = 3'd0;
                    acc_next   = 64'd0;
                    phase_next = srsp_pkg::PH_VER;
                end
                else
                begin
                    idx_next = idx_inc;
                end
            end
            srsp_pkg::PH_VER:
            begin
                kind     = srsp_pkg::KIND_HEADER;
                idx_next = idx_inc;
                acc_next = acc_or;
                if (idx_inc == 3'd4)
                begin
                    idx_next = 3'd0;
                    acc_next = 64'd0;
                    if (acc_or[31:0] != expected_version)
                    begin
                        status_next = srsp_pkg::STAT_BAD_VERSION;
                        phase_next  = srsp_pkg::PH_STOP;
                    end
                    else
                    begin
                        phase_next = srsp_pkg::PH_TIME;
                    end
                end
            end
            srsp_pkg::PH_TIME:
            begin
                kind     = srsp_pkg::KIND_HEADER;
                idx_next = idx_inc;
                acc_next = acc_or;
                if (idx_inc == 3'd0)
                begin
                    header_time_next = acc_or;
                    acc_next         = 64'd0;
                    phase_next       = srsp_pkg::PH_COUNT;
                end
            end
            srsp_pkg::PH_COUNT:
            begin
                kind     = srsp_pkg::KIND_HEADER;
                idx_next = idx_inc;
                acc_next = acc_or;
                if (idx_inc == 3'd0)
                begin
                    record_total_next = acc_or;
                    records_left_next = acc_or;
                    acc_next          = 64'd0;
                    phase_next        = (acc_or != 64'd0) ? srsp_pkg::PH_KLEN
                                                          : srsp_pkg::PH_CSUM;
                end
            end
            srsp_pkg::PH_KLEN:
            begin
                kind     = srsp_pkg::KIND_LENGTH;
                idx_next = idx_inc;
                acc_next = acc_or;
                if (idx_inc == 3'd4)
                begin
                    idx_next          = 3'd0;
                    acc_next          = 64'd0;
                    hash_next         = 32'd0;
                    payload_left_next = acc_or[31:0];
                    if (acc_or[31:0] == 32'd0)
                    begin
                        kend       = 1'b1;
                        phase_next = srsp_pkg::PH_VLEN;
                    end
                    else
                    begin
                        phase_next = srsp_pkg::PH_KEY;
                    end
                end
            end
            srsp_pkg::PH_KEY:
            begin
                kind              = srsp_pkg::KIND_KEY;
                hash_next         = hash_step;
                payload_left_next = payload_left_reg - 32'd1;
                if (payload_left_reg == 32'd1)
                begin
                    kend       = 1'b1;
                    sum_next   = sum_reg + hash_step;
                    phase_next = srsp_pkg::PH_VLEN;
                end
            end
            srsp_pkg::PH_VLEN:
            begin
                kind     = srsp_pkg::KIND_LENGTH;
                idx_next = idx_inc;
                acc_next = acc_or;
                if (idx_inc == 3'd4)
                begin
                    idx_next          = 3'd0;
                    acc_next          = 64'd0;
                    hash_next         = 32'd0;
                    payload_left_next = acc_or[31:0];
                    if (acc_or[31:0] == 32'd0)
                    begin
                        // empty value closes the record here
                        rend              = 1'b1;
                        record_index_next = record_index_reg + 64'd1;
                        records_left_next = records_dec;
                        phase_next        = (records_dec != 64'd0) ? srsp_pkg::PH_KLEN
                                                                   : srsp_pkg::PH_CSUM;
                    end
                    else
                    begin
                        phase_next = srsp_pkg::PH_VAL;
                    end
                end
            end
            srsp_pkg::PH_VAL:
            begin
                kind              = srsp_pkg::KIND_VALUE;
                hash_next         = hash_step;
                payload_left_next = payload_left_reg - 32'd1;
                if (payload_left_reg == 32'd1)
                begin
                    rend              = 1'b1;
                    sum_next          = sum_reg + hash_step;
                    record_index_next = record_index_reg + 64'd1;
                    records_left_next = records_dec;
                    phase_next        = (records_dec != 64'd0) ? srsp_pkg::PH_KLEN
                                                               : srsp_pkg::PH_CSUM;
                end
            end
            srsp_pkg::PH_CSUM:
            begin
                kind     = srsp_pkg::KIND_CSUM;
                idx_next = idx_inc;
                acc_next = acc_or;
                if (idx_inc == 3'd4)
                begin
                    idx_next    = 3'd0;
                    acc_next    = 64'd0;
                    status_next = (acc_or[31:0] == sum_reg) ? srsp_pkg::STAT_MATCH
                                                            : srsp_pkg::STAT_MISMATCH;
                    phase_next  = srsp_pkg::PH_STOP;
                end
            end
            default:
            begin
                kind = srsp_pkg::KIND_IGNORED;
            end
        endcase

        st = status_next;
        if (item.is_last && st == srsp_pkg::STAT_BUSY)
        begin
            st = srsp_pkg::STAT_TRUNCATED;
        end

        result.byte_kind    = kind;
        result.data_byte    = b;
        result.key_end      = kend;
        result.record_end   = rend;
        result.entry_number = record_index_reg;
        result.entry_total  = record_total_next;
        result.saved_time   = header_time_next;
        result.status       = st;

        // re-arm for the next file
        if (item.is_last)
        begin
            phase_next        = srsp_pkg::PH_SIG;
            idx_next          = 3'd0;
            acc_next          = 64'd0;
            records_left_next = 64'd0;
            payload_left_next = 32'd0;
            hash_next         = 32'd0;
            sum_next          = 32'd0;
            record_total_next = 64'd0;
            header_time_next  = 64'd0;
            record_index_next = 64'd0;
            status_next       = srsp_pkg::STAT_BUSY;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= srsp_pkg::PH_SIG;
            idx_reg          <= 3'd0;
            acc_reg          <= 64'd0;
            records_left_reg <= 64'd0;
            payload_left_reg <= 32'd0;
            hash_reg         <= 32'd0;
            sum_reg          <= 32'd0;
            record_total_reg <= 64'd0;
            header_time_reg  <= 64'd0;
            record_index_reg <= 64'd0;
            status_reg       <= srsp_pkg::STAT_BUSY;
        end
        else if (step)
        begin
            phase_reg        <= phase_next;
            idx_reg          <= idx_next;
            acc_reg          <= acc_next;
            records_left_reg <= records_left_next;
            payload_left_reg <= payload_left_next;
            hash_reg         <= hash_next;
            sum_reg          <= sum_next;
            record_total_reg <= record_total_next;
            header_time_reg  <= header_time_next;
            record_index_reg <= record_index_next;
            status_reg       <= status_next;
        end
    end

endmodule

/* design/srsp_out_stage.sv */
// Result register with stall handling on the output channel.
// Depends on srsp_pkg.
module srsp_out_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  srsp_pkg::out_item_t result,
    output logic                room,
    output logic                out_valid,
    input  logic                out_stall,
    output srsp_pkg::out_item_t out_data
);

    logic                valid_reg, valid_next;
    srsp_pkg::out_item_t data_reg;

    // free when empty or when the held item leaves this cycle
    assign room = !valid_reg || !out_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

/* design/snapshot_record_stream_parser.sv */
// Top level of the snapshot record stream parser: input register,
// version register, parse core and result register.
// Depends on srsp_pkg, srsp_core and srsp_out_stage.
//
// Usage:
//   Input channel (in_valid / in_stall / in_data) carries one file byte per
//   item, with is_last on the final byte of a file. Output channel
//   (out_valid / out_stall / out_data) returns one tagged item per input
//   byte, in order. cfg_valid / cfg_ready / cfg_data writes the expected
//   version; cfg_ready is always high, write only while the block is idle.
//   A byte passes through the input register, then the result register.
//   Throughput: one byte per cycle while the receiver does not stall; the
//   per-byte step (gather, hash multiply-by-31 as shift and subtract,
//   64-bit count update) is combinational between the input register and
//   the result register. When the receiver stalls a held result, the result
//   register holds, an empty input register can still take one byte, and
//   in_stall is high while the input register is full, until the result leaves.
//   Reset: parse state returns to the start of a file, status busy, both
//   registers empty, expected version 1. Each is_last byte re-arms the
//   parse state; the expected version keeps its value.
module snapshot_record_stream_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  srsp_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output srsp_pkg::out_item_t out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [31:0]         cfg_data
);

    logic                in_valid_reg, in_valid_next;
    srsp_pkg::in_item_t  in_data_reg;
    logic [31:0]         version_reg;
    logic                room;
    logic                advance;
    logic                take;
    srsp_pkg::out_item_t result;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && room;
    assign in_stall  = in_valid_reg && !room;
    assign take      = in_valid && !in_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (!in_stall)
        begin
            in_valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            version_reg  <= srsp_pkg::VERSION_RESET;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                version_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_data_reg <= in_data;
        end
    end

    srsp_core u_core (
        .clk              (clk),
        .rst_n            (rst_n),
        .step             (advance),
        .item             (in_data_reg),
        .expected_version (version_reg),
        .result           (result)
    );

    srsp_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance),
        .result    (result),
        .room      (room),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

/* design/srsp_checker.sv */
// Port-level checks for the snapshot record stream parser, bound to the top.
// Depends on srsp_pkg and snapshot_record_stream_parser.
module srsp_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_stall,
    input srsp_pkg::out_item_t out_data
);

    // a stalled result stays put
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    // bytes after a verdict carry no marks
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.byte_kind == srsp_pkg::KIND_IGNORED
        |-> !out_data.key_end && !out_data.record_end)
        else $error("ignored byte carries a mark");

    // an ignored byte only follows a verdict
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.byte_kind == srsp_pkg::KIND_IGNORED
        |-> out_data.status != srsp_pkg::STAT_BUSY)
        else $error("ignored byte without verdict");

    // header bytes belong to no record
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.byte_kind == srsp_pkg::KIND_HEADER
        |-> out_data.entry_number == 64'd0)
        else $error("header byte with nonzero entry number");

endmodule

bind snapshot_record_stream_parser srsp_checker u_srsp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

/* test/tb.sv */
// Self-checking bench for the snapshot record stream parser: framed files,
// broken files and byte noise, checked item by item against a behavioral parser.
// Depends on srsp_pkg and snapshot_record_stream_parser.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import srsp_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam logic [47:0] SIG_CHARS = 48'h4F_72_63_61_44_42;

    typedef enum int {
        FLAW_NONE,
        FLAW_MAGIC,
        FLAW_VERSION,
        FLAW_CSUM,
        FLAW_CUT,
        FLAW_TAIL
    } flaw_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       typed;
        logic [2:0] kind;
        logic [2:0] stat;
    } probe_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    in_item_t    in_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    out_item_t   out_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data = '0;

    // Parser mirror
    logic [31:0] ver_reg;
    phase_t      ph;
    logic [2:0]  fld_idx;
    logic [63:0] fld_acc;
    logic [63:0] recs_left;
    logic [31:0] bytes_left;
    logic [31:0] fld_hash;
    logic [31:0] hash_sum;
    logic [63:0] rec_total;
    logic [63:0] stamp;
    logic [63:0] recs_done;
    logic [2:0]  verdict;

    out_item_t   tags_due[$];
    int          bytes_in = 0;
    int          tags_checked = 0;
    int          files_sent = 0;
    int          errors = 0;
    int          cycles = 0;
    bit          calm_mode = 1'b0;
    bit          squeeze_req = 1'b0;
    int          hold_left = 0;
    int          stall_left = 0;

    probe_row_t opening_rows [18] = '{
        '{8'h00, 1'b0, 1'b1, KIND_HEADER,  STAT_BAD_MAGIC},
        '{8'hFF, 1'b0, 1'b1, KIND_IGNORED, STAT_BAD_MAGIC},
        '{8'h00, 1'b1, 1'b1, KIND_IGNORED, STAT_BAD_MAGIC},
        '{8'h4F, 1'b1, 1'b1, KIND_HEADER,  STAT_TRUNCATED},
        '{8'h4F, 1'b0, 1'b1, KIND_HEADER,  STAT_BUSY},
        '{8'h72, 1'b0, 1'b1, KIND_HEADER,  STAT_BUSY},
        '{8'h63, 1'b0, 1'b1, KIND_HEADER,  STAT_BUSY},
        '{8'h61, 1'b0, 1'b1, KIND_HEADER,  STAT_BUSY},
        '{8'h44, 1'b0, 1'b1, KIND_HEADER,  STAT_BUSY},
        '{8'h42, 1'b0, 1'b1, KIND_HEADER,  STAT_BUSY},
        // seventh signature byte is not checked
        '{8'hFF, 1'b0, 1'b1, KIND_HEADER,  STAT_BUSY},
        '{8'h02, 1'b0, 1'b0, 3'd0,         3'd0},
        '{8'h00, 1'b0, 1'b0, 3'd0,         3'd0},
        '{8'h00, 1'b0, 1'b0, 3'd0,         3'd0},
        '{8'h00, 1'b0, 1'b1, KIND_HEADER,  STAT_BAD_VERSION},
        '{8'h00, 1'b1, 1'b1, KIND_IGNORED, STAT_BAD_VERSION},
        '{8'h4F, 1'b0, 1'b0, 3'd0,         3'd0},
        // verdict on the final byte beats truncation
        '{8'h00, 1'b1, 1'b1, KIND_HEADER,  STAT_BAD_MAGIC}
    };

    snapshot_record_stream_parser dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void clear_parse();
        ph = PH_SIG;
        fld_idx = '0;
        fld_acc = '0;
        recs_left = '0;
        bytes_left = '0;
        fld_hash = '0;
        hash_sum = '0;
        rec_total = '0;
        stamp = '0;
        recs_done = '0;
        verdict = STAT_BUSY;
    endfunction

    // Gather one little-endian byte; true once n bytes are in (n of 0 means eight).
    function automatic bit take_le(input logic [7:0] b, input logic [2:0] n);
        fld_acc = fld_acc | (64'(b) << (8 * fld_idx));
        fld_idx = fld_idx + 3'd1;
        if (fld_idx == n)
        begin
            fld_idx = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void close_record();
        recs_done = recs_done + 64'd1;
        recs_left = recs_left - 64'd1;
        ph = (recs_left != 0) ? PH_KLEN : PH_CSUM;
    endfunction

    function automatic out_item_t tag_byte(input logic [7:0] b, input logic last);
        out_item_t r;
        r = '0;
        r.byte_kind = KIND_IGNORED;
        r.data_byte = b;
        r.entry_number = recs_done;
        case (ph)
            PH_SIG:
            begin
                r.byte_kind = KIND_HEADER;
                if (fld_idx < SIG_LEN && b != SIG_CHARS[47 - 8 * fld_idx -: 8])
                begin
                    verdict = STAT_BAD_MAGIC;
                    ph = PH_STOP;
                end
                else
                begin
                    fld_idx = fld_idx + 3'd1;
                    if (fld_idx == 3'd7)
                    begin
                        fld_idx = '0;
                        fld_acc = '0;
                        ph = PH_VER;
                    end
                end
            end
            PH_VER:
            begin
                r.byte_kind = KIND_HEADER;
                if (take_le(b, 3'd4))
                begin
                    if (fld_acc[31:0] != ver_reg)
                    begin
                        verdict = STAT_BAD_VERSION;
                        ph = PH_STOP;
                    end
                    else
                        ph = PH_TIME;
                    fld_acc = '0;
                end
            end
            PH_TIME:
            begin
                r.byte_kind = KIND_HEADER;
                if (take_le(b, 3'd0))
                begin
                    stamp = fld_acc;
                    fld_acc = '0;
                    ph = PH_COUNT;
                end
            end
            PH_COUNT:
            begin
                r.byte_kind = KIND_HEADER;
                if (take_le(b, 3'd0))
                begin
                    rec_total = fld_acc;
                    recs_left = fld_acc;
                    fld_acc = '0;
                    ph = (recs_left != 0) ? PH_KLEN : PH_CSUM;
                end
            end
            PH_KLEN, PH_VLEN:
            begin
                r.byte_kind = KIND_LENGTH;
                if (take_le(b, 3'd4))
                begin
                    bytes_left = fld_acc[31:0];
                    fld_acc = '0;
                    fld_hash = '0;
                    if (ph == PH_KLEN)
                    begin
                        r.key_end = (bytes_left == 0);
                        ph = (bytes_left == 0) ? PH_VLEN : PH_KEY;
                    end
                    else if (bytes_left == 0)
                    begin
                        r.record_end = 1'b1;
                        close_record();
                    end
                    else
                        ph = PH_VAL;
                end
            end
            PH_KEY, PH_VAL:
            begin
                r.byte_kind = (ph == PH_KEY) ? KIND_KEY : KIND_VALUE;
                fld_hash = fld_hash * 32'd31 + 32'(b);
                bytes_left = bytes_left - 32'd1;
                if (bytes_left == 0)
                begin
                    hash_sum = hash_sum + fld_hash;
                    if (ph == PH_KEY)
                    begin
                        r.key_end = 1'b1;
                        ph = PH_VLEN;
                    end
                    else
                    begin
                        r.record_end = 1'b1;
                        close_record();
                    end
                end
            end
            PH_CSUM:
            begin
                r.byte_kind = KIND_CSUM;
                if (take_le(b, 3'd4))
                begin
                    verdict = (fld_acc[31:0] == hash_sum) ? STAT_MATCH : STAT_MISMATCH;
                    fld_acc = '0;
                    ph = PH_STOP;
                end
            end
            default:
                r.byte_kind = KIND_IGNORED;
        endcase
        r.entry_total = rec_total;
        r.saved_time = stamp;
        r.status = (last && verdict == STAT_BUSY) ? STAT_TRUNCATED : verdict;
        if (last)
            clear_parse();
        return r;
    endfunction

    // Mostly back to back, sometimes a short gap, rarely a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm_mode || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    task automatic check_field(input string name, input logic [63:0] exp,
                               input logic [63:0] act);
        if (exp !== act)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp, act);
        end
    endtask

    // Result side: check each accepted item, then pick the next stall.
    always @(posedge clk)
    begin
        out_item_t e;
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d results still due", cycles, tags_due.size());
            $display("CHECKS FAILED");
            $finish;
        end
        if (rst_n && out_valid && !out_stall)
        begin
            if (tags_due.size() == 0)
            begin
                errors++;
                $display("%0t: result with nothing due, expected none, got %0h", $time,
                         out_data);
            end
            else
            begin
                e = tags_due.pop_front();
                tags_checked++;
                check_field("byte_kind", 64'(e.byte_kind), 64'(out_data.byte_kind));
                check_field("data_byte", 64'(e.data_byte), 64'(out_data.data_byte));
                check_field("key_end", 64'(e.key_end), 64'(out_data.key_end));
                check_field("record_end", 64'(e.record_end), 64'(out_data.record_end));
                check_field("entry_number", e.entry_number, out_data.entry_number);
                check_field("entry_total", e.entry_total, out_data.entry_total);
                check_field("saved_time", e.saved_time, out_data.saved_time);
                check_field("status", 64'(e.status), 64'(out_data.status));
            end
        end
        if (squeeze_req)
        begin
            hold_left = 80;
            squeeze_req = 1'b0;
        end
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else
        begin
            stall_left = pick_gap();
            out_stall <= (stall_left != 0);
            if (stall_left != 0)
                stall_left--;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last,
                             input logic typed = 1'b0, input logic [2:0] kind = '0,
                             input logic [2:0] stat = '0);
        int gap;
        out_item_t r;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= '{byte_value: b, is_last: last};
        do
            @(posedge clk);
        while (in_stall);
        bytes_in++;
        r = tag_byte(b, last);
        if (typed)
        begin
            r.byte_kind = kind;
            r.status = stat;
        end
        tags_due.push_back(r);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (tags_due.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_version(input logic [31:0] v);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        ver_reg = v;
    endtask

    // Build one file with nrec records and an optional flaw, then stream it.
    task automatic send_file(input int nrec, input int maxlen, input flaw_t flaw);
        logic [7:0]  fb[$];
        logic [31:0] ver;
        logic [31:0] sum;
        logic [31:0] h;
        logic [31:0] len;
        logic [63:0] tstamp;
        logic [63:0] cnt;
        logic [7:0]  bv;
        int          idx;
        int          n_send;
        for (int i = 0; i < 6; i++)
            fb.push_back(SIG_CHARS[47 - 8 * i -: 8]);
        fb.push_back(8'($urandom));
        ver = ver_reg;
        if (flaw == FLAW_VERSION)
            ver = ver ^ (32'd1 << $urandom_range(0, 31));
        for (int i = 0; i < 4; i++)
            fb.push_back(ver[8 * i +: 8]);
        tstamp = {$urandom, $urandom};
        for (int i = 0; i < 8; i++)
            fb.push_back(tstamp[8 * i +: 8]);
        cnt = 64'(nrec);
        if (flaw == FLAW_CUT && $urandom_range(0, 1) == 1)
            cnt = {$urandom, $urandom};
        for (int i = 0; i < 8; i++)
            fb.push_back(cnt[8 * i +: 8]);
        sum = '0;
        for (int rec = 0; rec < nrec; rec++)
        begin
            // key then value: length, then bytes hashed into the running sum
            for (int part = 0; part < 2; part++)
            begin
                len = 32'($urandom_range(0, maxlen));
                for (int i = 0; i < 4; i++)
                    fb.push_back(len[8 * i +: 8]);
                h = '0;
                for (int i = 0; i < len; i++)
                begin
                    bv = 8'($urandom);
                    fb.push_back(bv);
                    h = h * 32'd31 + 32'(bv);
                end
                sum = sum + h;
            end
        end
        if (flaw == FLAW_CSUM)
            sum = sum ^ (32'd1 << $urandom_range(0, 31));
        for (int i = 0; i < 4; i++)
            fb.push_back(sum[8 * i +: 8]);
        if (flaw == FLAW_MAGIC)
        begin
            idx = $urandom_range(0, 5);
            fb[idx] = fb[idx] ^ (8'd1 << $urandom_range(0, 7));
        end
        if (flaw == FLAW_TAIL)
            repeat ($urandom_range(1, 6)) fb.push_back(8'($urandom));
        n_send = fb.size();
        if (flaw == FLAW_CUT)
            n_send = $urandom_range(1, fb.size() - 1);
        for (int i = 0; i < n_send; i++)
            send_byte(fb[i], i == n_send - 1);
        files_sent++;
    endtask

    task automatic send_noise(input int n);
        for (int i = 0; i < n; i++)
            send_byte(8'($urandom), i == n - 1 || $urandom_range(0, 7) == 0);
    endtask

    initial
    begin
        logic [31:0] settings [4];
        int          r;
        int          nrec;
        int          maxlen;
        flaw_t       flaw;

        ver_reg = VERSION_RESET;
        clear_parse();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < $size(opening_rows); i++)
            send_byte(opening_rows[i].data, opening_rows[i].last, opening_rows[i].typed,
                      opening_rows[i].kind, opening_rows[i].stat);

        settings[0] = 32'hFFFF_FFFF;
        settings[1] = 32'h0000_0000;
        settings[2] = $urandom;
        settings[3] = VERSION_RESET;
        for (int p = 0; p < 4; p++)
        begin
            wait_drained();
            write_version(settings[p]);
            if (p == 0)
                send_file(0, 0, FLAW_NONE);
            if (p == 2)
            begin
                // long receiver hold while bytes keep coming
                calm_mode = 1'b1;
                squeeze_req = 1'b1;
                send_file(3, 6, FLAW_NONE);
            end
            while (bytes_in < 18 + 125 * (p + 1))
            begin
                calm_mode = ($urandom_range(0, 4) == 0);
                r = $urandom_range(0, 99);
                nrec = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 8) : $urandom_range(0, 3);
                maxlen = ($urandom_range(0, 9) == 0) ? 40 : 5;
                if (r < 58)
                    flaw = FLAW_NONE;
                else if (r < 66)
                    flaw = FLAW_MAGIC;
                else if (r < 72)
                    flaw = FLAW_VERSION;
                else if (r < 80)
                    flaw = FLAW_CSUM;
                else if (r < 90)
                    flaw = FLAW_CUT;
                else
                    flaw = FLAW_TAIL;
                if (r >= 96)
                    send_noise($urandom_range(3, 16));
                else
                    send_file(nrec, maxlen, flaw);
            end
        end
        calm_mode = 1'b0;
        wait_drained();
        repeat (5) @(posedge clk);

        $display("Sent %0d bytes in %0d files plus noise over 5 version settings;", bytes_in,
                 files_sent);
        $display("checked %0d tagged results, %0d field mismatches.", tags_checked, errors);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
